>>> sv/bdth_pkg.sv
// Package for the debounced button tap/hold detector.
// Holds payload structs, register indexes and fixed field widths; no dependencies.
package bdth_pkg;

  localparam int PAGE_BITS = 8;
  localparam int CFG_W     = 16;

  localparam logic LEVEL_HIGH = 1'b1;
  localparam logic LEVEL_LOW  = 1'b0;

  typedef enum logic [0:0] {
    CFG_DEBOUNCE   = 1'b0,
    CFG_LONG_PRESS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                 button_level;
    logic                 screensaver_on;
    logic                 dashboard_ok;
    logic [PAGE_BITS-1:0] page_count;
    logic [PAGE_BITS-1:0] current_page;
  } in_item_t;

  typedef struct packed {
    logic                 activity;
    logic                 wake;
    logic                 refresh_request;
    logic                 skip;
    logic [PAGE_BITS-1:0] next_page;
    logic                 held;
  } out_item_t;

endpackage

>>> sv/button_debounce_tap_hold_top.sv
// Debounced button with short-tap skip and long-press refresh detection.
// Depends on bdth_pkg for payload structs and register indexes.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------
//   in_     | input     | in_valid/in_stall  | bdth_pkg::in_item_t
//   out_    | output    | out_valid/out_stall| bdth_pkg::out_item_t
//   cfg_    | input     | cfg_we (no wait)   | cfg_index, cfg_wdata
//
// One tick per clock cycle while in_stall is low: each beat updates the counters
// and debounce state in the cycle it is taken, and its result lands in the output
// register on the same edge. A held result stalls input only while out_stall
// is high; taking the result frees the register for a new beat in that same
// cycle. Reset (rst_n low, synchronous) restores the documented state and
// register defaults and empties the output register.
module button_debounce_tap_hold_top #(
  parameter int TIMER_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bdth_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bdth_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  bdth_pkg::cfg_idx_t             cfg_index,
  input  logic [bdth_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int CMP_W = (TIMER_BITS > bdth_pkg::CFG_W) ? TIMER_BITS : bdth_pkg::CFG_W;
  localparam int PB    = bdth_pkg::PAGE_BITS;

  logic [bdth_pkg::CFG_W-1:0] debounce_r;
  logic [bdth_pkg::CFG_W-1:0] long_press_r;

  logic                  last_raw_r,      last_raw_nxt;
  logic                  stable_r,        stable_nxt;
  logic [TIMER_BITS-1:0] since_r,         since_nxt;
  logic [TIMER_BITS-1:0] hold_r,          hold_nxt;
  logic                  long_fired_r,    long_fired_nxt;
  logic                  began_data_r,    began_data_nxt;

  logic                  out_valid_r;
  bdth_pkg::out_item_t   out_data_r,      out_data_nxt;

  logic                  in_take;
  logic                  pressed_now;
  logic                  settled;
  logic [TIMER_BITS-1:0] hold_step;
  logic [PB:0]           page_inc;

  assign in_stall  = out_valid_r && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    last_raw_nxt   = last_raw_r;
    stable_nxt     = stable_r;
    long_fired_nxt = long_fired_r;
    began_data_nxt = began_data_r;
    out_data_nxt   = '0;

    // restart the stability count on any raw change, else count up and saturate
    if (in_data.button_level != last_raw_r) begin
      since_nxt    = '0;
      last_raw_nxt = in_data.button_level;
    end else begin
      since_nxt = (since_r == '1) ? since_r : since_r + 1'b1;
    end

    hold_step = (stable_r && hold_r != '1) ? hold_r + 1'b1 : hold_r;
    hold_nxt  = hold_step;

    pressed_now = (in_data.button_level == bdth_pkg::LEVEL_LOW);
    settled     = CMP_W'(since_nxt) > CMP_W'(debounce_r);
    page_inc    = {1'b0, in_data.current_page} + 1'b1;

    if (settled) begin
      if (pressed_now && !stable_r) begin
        hold_nxt              = '0;
        long_fired_nxt        = 1'b0;
        began_data_nxt        = !in_data.screensaver_on;
        out_data_nxt.activity = 1'b1;
        out_data_nxt.wake     = in_data.screensaver_on;
      end else if (pressed_now && stable_r && !long_fired_r && began_data_r &&
                   CMP_W'(hold_step) >= CMP_W'(long_press_r)) begin
        long_fired_nxt               = 1'b1;
        out_data_nxt.refresh_request = 1'b1;
      end else if (!pressed_now && stable_r) begin
        if (!long_fired_r && began_data_r && in_data.dashboard_ok &&
            in_data.page_count != '0) begin
          out_data_nxt.skip      = 1'b1;
          // wrap by comparison: out-of-range pages fall back to the first
          out_data_nxt.next_page = (page_inc >= {1'b0, in_data.page_count}) ?
                                   '0 : page_inc[PB-1:0];
        end
      end
      stable_nxt = pressed_now;
    end

    out_data_nxt.held = stable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= bdth_pkg::CFG_W'(50);
      long_press_r <= bdth_pkg::CFG_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdth_pkg::CFG_DEBOUNCE:   debounce_r   <= cfg_wdata;
        bdth_pkg::CFG_LONG_PRESS: long_press_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r   <= bdth_pkg::LEVEL_HIGH;
      stable_r     <= 1'b0;
      since_r      <= '0;
      hold_r       <= '0;
      long_fired_r <= 1'b0;
      began_data_r <= 1'b1;
    end else if (in_take) begin
      last_raw_r   <= last_raw_nxt;
      stable_r     <= stable_nxt;
      since_r      <= since_nxt;
      hold_r       <= hold_nxt;
      long_fired_r <= long_fired_nxt;
      began_data_r <= began_data_nxt;
    end
  end

  // output register: load on a taken beat, drop once the result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> out_valid_r)
    else $error("taken beat did not reach the output register");

  a_wake_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.wake) |-> out_data_r.activity)
    else $error("wake without a press edge");

  a_refresh_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.refresh_request) |-> (out_data_r.held && long_fired_r))
    else $error("refresh outside a long hold");

  a_skip_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.skip) |-> (!out_data_r.held && !out_data_r.activity))
    else $error("skip without a release");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench for button_debounce_tap_hold_top: directed taps, holds and bounces, then random
// press sequences under three handshake mixes, each beat checked against an in-bench predictor.
// Depends on bdth_pkg and the top level only.
module testbench;

  localparam int TIMER_BITS = 16;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam int QUIET_LIMIT = 2000;

  logic                          clk;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  bdth_pkg::in_item_t            in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  bdth_pkg::out_item_t           out_data;
  logic                          cfg_we    = 1'b0;
  bdth_pkg::cfg_idx_t            cfg_index = bdth_pkg::CFG_DEBOUNCE;
  logic [bdth_pkg::CFG_W-1:0]    cfg_wdata = '0;

  button_debounce_tap_hold_top #(.TIMER_BITS(TIMER_BITS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor copy of the registers and the debounce state
  logic [bdth_pkg::CFG_W-1:0] debounce_m, long_press_m;
  logic                       raw_last_m, pressed_m, long_done_m, press_in_data_m;
  logic [TIMER_BITS-1:0]      steady_age_m, hold_age_m;

  bdth_pkg::out_item_t due_results_q[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int ticks_sent    = 0;
  int mismatches    = 0;
  int presses_seen  = 0;
  int refresh_seen  = 0;
  int skips_seen    = 0;
  int quiet_cycles  = 0;

  task automatic reset_predictor();
    debounce_m      = 16'd50;
    long_press_m    = 16'd1000;
    raw_last_m      = bdth_pkg::LEVEL_HIGH;
    pressed_m       = 1'b0;
    steady_age_m    = '0;
    hold_age_m      = '0;
    long_done_m     = 1'b0;
    press_in_data_m = 1'b1;
  endtask

  function automatic bdth_pkg::out_item_t predict_tick(input bdth_pkg::in_item_t t);
    bdth_pkg::out_item_t r;
    logic [bdth_pkg::PAGE_BITS:0] nxt;
    r = '0;
    if (t.button_level != raw_last_m) begin
      steady_age_m = '0;
      raw_last_m   = t.button_level;
    end else if (steady_age_m != TIMER_MAX) begin
      steady_age_m = steady_age_m + 1'b1;
    end
    if (pressed_m && hold_age_m != TIMER_MAX) hold_age_m = hold_age_m + 1'b1;
    if (steady_age_m > debounce_m) begin
      if (t.button_level == bdth_pkg::LEVEL_LOW && !pressed_m) begin
        hold_age_m      = '0;
        long_done_m     = 1'b0;
        press_in_data_m = !t.screensaver_on;
        r.activity      = 1'b1;
        r.wake          = t.screensaver_on;
      end else if (t.button_level == bdth_pkg::LEVEL_LOW && pressed_m && !long_done_m &&
                   press_in_data_m && hold_age_m >= long_press_m) begin
        long_done_m       = 1'b1;
        r.refresh_request = 1'b1;
      end else if (t.button_level == bdth_pkg::LEVEL_HIGH && pressed_m) begin
        // short tap: only when nothing fired, the press began in data mode and the dashboard is valid and non-empty
        if (!long_done_m && press_in_data_m && t.dashboard_ok && t.page_count != 0) begin
          nxt         = {1'b0, t.current_page} + 1'b1;
          r.skip      = 1'b1;
          r.next_page = (nxt >= t.page_count) ? '0 : nxt[bdth_pkg::PAGE_BITS-1:0];
        end
      end
      pressed_m = (t.button_level == bdth_pkg::LEVEL_LOW);
    end
    r.held = pressed_m;
    return r;
  endfunction

  function automatic bdth_pkg::in_item_t make_tick(input logic level, input logic saver,
                                                   input logic dash, input int cnt,
                                                   input int pg);
    bdth_pkg::in_item_t t;
    t.button_level   = level;
    t.screensaver_on = saver;
    t.dashboard_ok   = dash;
    t.page_count     = cnt[bdth_pkg::PAGE_BITS-1:0];
    t.current_page   = pg[bdth_pkg::PAGE_BITS-1:0];
    return t;
  endfunction

  function automatic bdth_pkg::in_item_t random_tick(input logic level, input logic saver);
    int cnt, pg;
    case ($urandom_range(7))
      0:       cnt = 0;
      1:       cnt = 1;
      2:       cnt = 255;
      default: cnt = $urandom_range(0, 255);
    endcase
    // aim near the wrap point a third of the time
    if (cnt > 0 && $urandom_range(2) == 0) pg = (cnt >= 2) ? cnt - 2 + $urandom_range(1) : 0;
    else pg = $urandom_range(0, 254);
    return make_tick(level, saver, $urandom_range(7) != 0, cnt, pg);
  endfunction

  task automatic send_tick(input bdth_pkg::in_item_t t);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    due_results_q.push_back(predict_tick(t));
    ticks_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_results_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_config(input logic [bdth_pkg::CFG_W-1:0] deb,
                            input logic [bdth_pkg::CFG_W-1:0] longp);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= bdth_pkg::CFG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    debounce_m = deb;
    cfg_index <= bdth_pkg::CFG_LONG_PRESS;
    cfg_wdata <= longp;
    @(posedge clk);
    long_press_m = longp;
    cfg_we <= 1'b0;
  endtask

  task automatic hold_level(input logic level, input logic saver, input int n);
    repeat (n) send_tick(make_tick(level, saver, 1'b1, 8, 2));
  endtask

  task automatic tap(input int cnt, input int pg, input logic dash);
    repeat (2) send_tick(make_tick(bdth_pkg::LEVEL_LOW, 1'b0, dash, cnt, pg));
    repeat (2) send_tick(make_tick(bdth_pkg::LEVEL_HIGH, 1'b0, dash, cnt, pg));
  endtask

  task automatic test_short_taps();
    set_config(16'd0, 16'd8);
    tap(5, 4, 1'b1);      // wraps to page 0
    tap(3, 200, 1'b1);    // page beyond the count
    tap(255, 253, 1'b1);  // largest next page
    tap(0, 7, 1'b1);      // empty dashboard: no skip
    tap(9, 2, 1'b0);      // dashboard not valid: no skip
  endtask

  task automatic test_long_press();
    set_config(16'd0, 16'd0);
    hold_level(bdth_pkg::LEVEL_LOW, 1'b0, 4);
    hold_level(bdth_pkg::LEVEL_HIGH, 1'b0, 2);
  endtask

  task automatic test_screensaver_press();
    set_config(16'd0, 16'd1);
    hold_level(bdth_pkg::LEVEL_LOW, 1'b1, 5);
    hold_level(bdth_pkg::LEVEL_HIGH, 1'b0, 2);
  endtask

  task automatic test_debounce_ceiling();
    set_config(16'hFFFF, 16'd1);
    repeat (2) begin
      send_tick(random_tick(bdth_pkg::LEVEL_LOW, 1'b0));
      send_tick(random_tick(bdth_pkg::LEVEL_HIGH, 1'b1));
    end
  endtask

  task automatic run_gestures(input int n_ticks);
    int stop_at, press_n, glitches;
    logic saver;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      saver = ($urandom_range(3) == 0);
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 8))
          send_tick(random_tick($urandom_range(1) == 1, $urandom_range(1) == 1));
      end else begin
        glitches = $urandom_range(0, 3);
        repeat (glitches) begin
          send_tick(random_tick(bdth_pkg::LEVEL_LOW, saver));
          send_tick(random_tick(bdth_pkg::LEVEL_HIGH, saver));
        end
        press_n = int'(debounce_m) + 2 + int'($urandom_range(0, int'(long_press_m) + 4));
        // now and then cut the press short of the debounce window
        if ($urandom_range(9) == 0) press_n = int'($urandom_range(1, int'(debounce_m) + 1));
        repeat (press_n) send_tick(random_tick(bdth_pkg::LEVEL_LOW, saver));
        repeat (glitches) begin
          send_tick(random_tick(bdth_pkg::LEVEL_HIGH, saver));
          send_tick(random_tick(bdth_pkg::LEVEL_LOW, saver));
        end
        repeat (int'(debounce_m) + 2 + int'($urandom_range(0, 3)))
          send_tick(random_tick(bdth_pkg::LEVEL_HIGH, saver));
      end
    end
  endtask

  task automatic test_random_presses(input int n_ticks);
    repeat (3) begin
      set_config(bdth_pkg::CFG_W'(($urandom_range(4) == 0) ? $urandom_range(4, 12)
                                                           : $urandom_range(0, 3)),
                 bdth_pkg::CFG_W'(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12)));
      run_gestures(n_ticks / 3);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= rst_n && recv_idle_pct != 0 && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    bdth_pkg::out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (due_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        want = due_results_q.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected act=%b wake=%b refresh=%b skip=%b ",
                      "next=%0d held=%b, got act=%b wake=%b refresh=%b skip=%b ",
                      "next=%0d held=%b"},
                     want.activity, want.wake, want.refresh_request, want.skip,
                     want.next_page, want.held, out_data.activity, out_data.wake,
                     out_data.refresh_request, out_data.skip, out_data.next_page,
                     out_data.held);
        end
        presses_seen += want.activity;
        refresh_seen += want.refresh_request;
        skips_seen   += want.skip;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, due_results_q.size());
      $display("FAIL button_debounce_tap_hold_top");
      $finish;
    end
  end

  initial begin
    reset_predictor();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 19;
    recv_idle_pct = 73;
    test_short_taps();
    test_long_press();
    test_screensaver_press();
    test_debounce_ceiling();
    test_random_presses(180);

    send_idle_pct = 73;
    recv_idle_pct = 19;
    test_random_presses(180);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_presses(180);

    drain();
    $display("Covered %0d ticks under three stall mixes: %0d debounced presses,",
             ticks_sent, presses_seen);
    $display("%0d long presses, %0d page skips and a debounce ceiling; %0d mismatches.",
             refresh_seen, skips_seen, mismatches);
    if (mismatches == 0 && due_results_q.size() == 0) begin
      $display("PASS button_debounce_tap_hold_top");
    end else begin
      $display("FAIL button_debounce_tap_hold_top");
    end
    $finish;
  end

endmodule
